@@ rtl/bomset_pkg.sv @@
// shared types and constants for the bounded ordered member set
`timescale 1ns / 1ps

package bomset_pkg;

  // fixed field widths of the request and result
  localparam int KIND_W   = 2;
  localparam int MEMBER_W = 8;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_PRESENT   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_CHECK,
    ST_SHIFT_FETCH,
    ST_SHIFT_WRITE,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // memory read address source
  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_POS
  } rd_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;        // capture request fields, clear index and status
    rd_sel_t rd_sel;      // read address for this cycle
    logic    idx_inc;     // step the scan index
    logic    append;      // write member at the tail, count up
    logic    shift_wr;    // move fetched entry down one place
    logic    cnt_dec;     // count down after a remove
    logic    cnt_clear;   // empty the list
    logic    stat_set;    // record a non-ok status
    status_t stat_code;
    logic    rd_capture;  // keep fetched entry as read result
    logic    res_load;    // move result into output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  scan_end;
    logic  match;
    logic  shift_end;
    logic  in_range;
    logic  out_free;
  } dp_stat_t;

endpackage

@@ rtl/bomset_ctrl.sv @@
// controller state machine for the bounded ordered member set
`timescale 1ns / 1ps

module bomset_ctrl
  import bomset_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // take a new request only when idle
  assign in_stall = rst || (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.kind)
          KIND_ADD:    state_next = stat.full ? ST_DONE : ST_FETCH;
          KIND_REMOVE: state_next = ST_FETCH;
          KIND_CLEAR:  state_next = ST_DONE;
          KIND_READ:   state_next = stat.in_range ? ST_READ_WAIT : ST_DONE;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_FETCH: begin
        state_next = stat.scan_end ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.match) begin
          state_next = ST_FETCH;
        end else if (stat.kind == KIND_REMOVE) begin
          state_next = ST_SHIFT_FETCH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT_FETCH: begin
        state_next = stat.shift_end ? ST_DONE : ST_SHIFT_WRITE;
      end
      ST_SHIFT_WRITE: begin
        state_next = ST_SHIFT_FETCH;
      end
      ST_READ_WAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.stat_code  = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid && !rst;
      end
      ST_DISPATCH: begin
        unique case (stat.kind)
          KIND_ADD: begin
            if (stat.full) begin
              cmd.stat_set  = 1'b1;
              cmd.stat_code = STAT_FULL;
            end
          end
          KIND_REMOVE: begin
          end
          KIND_CLEAR: begin
            cmd.cnt_clear = 1'b1;
          end
          KIND_READ: begin
            if (stat.in_range) begin
              cmd.rd_sel = RD_POS;
            end else begin
              cmd.stat_set  = 1'b1;
              cmd.stat_code = STAT_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      ST_FETCH: begin
        cmd.rd_sel = RD_IDX;
        if (stat.scan_end) begin
          if (stat.kind == KIND_ADD) begin
            cmd.append = 1'b1;
          end else begin
            cmd.stat_set  = 1'b1;
            cmd.stat_code = STAT_NOT_FOUND;
          end
        end
      end
      ST_CHECK: begin
        if (!stat.match) begin
          cmd.idx_inc = 1'b1;
        end else if (stat.kind != KIND_REMOVE) begin
          cmd.stat_set  = 1'b1;
          cmd.stat_code = STAT_PRESENT;
        end
      end
      ST_SHIFT_FETCH: begin
        cmd.rd_sel = RD_NEXT;
        if (stat.shift_end) begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ST_SHIFT_WRITE: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      ST_READ_WAIT: begin
        cmd.rd_capture = 1'b1;
      end
      ST_DONE: begin
        cmd.res_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/bomset_dp.sv @@
// datapath: member memory, count, scan index and result register
`timescale 1ns / 1ps

module bomset_dp
  import bomset_pkg::*;
#(
  parameter int MAX_MEMBERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KIND_W-1:0]   kind,
  input  logic [MEMBER_W-1:0] member_number,
  input  logic [POS_W-1:0]    slot_position,
  input  cmd_t                cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [MEMBER_W-1:0] read_member,
  output logic [COUNT_W-1:0]  member_count
);

  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // captured request
  kind_t               kind_q;
  logic [MEMBER_W-1:0] num_q;
  logic [POS_W-1:0]    pos_q;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W:0]      idx_plus;
  status_t             stat_q;
  logic [MEMBER_W-1:0] read_val;

  // member memory
  logic [MEMBER_W-1:0] mem [MAX_MEMBERS];
  logic [MEMBER_W-1:0] rdata;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [MEMBER_W-1:0] wdata;
  logic                we;

  assign idx_plus = {1'b0, idx} + (CNT_W + 1)'(1);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind_t'(kind);
      num_q  <= member_number;
      pos_q  <= slot_position;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus[CNT_W-1:0];
    end
  end

  // member count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.append) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // operation status and read value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stat_q   <= STAT_OK;
      read_val <= '0;
    end else begin
      if (cmd.stat_set) begin
        stat_q <= cmd.stat_code;
      end
      if (cmd.rd_capture) begin
        read_val <= rdata;
      end
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  raddr = idx[IDX_W-1:0];
      RD_NEXT: raddr = idx_plus[IDX_W-1:0];
      RD_POS:  raddr = IDX_W'(pos_q);
      default: raddr = idx[IDX_W-1:0];
    endcase
  end

  // write port: append at tail or shift down
  always_comb begin
    we    = cmd.append || cmd.shift_wr;
    waddr = cmd.append ? cnt[IDX_W-1:0] : idx[IDX_W-1:0];
    wdata = cmd.append ? num_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // status toward the controller
  always_comb begin
    stat.kind      = kind_q;
    stat.full      = (cnt >= CNT_W'(MAX_MEMBERS));
    stat.scan_end  = (idx >= cnt);
    stat.match     = (rdata == num_q);
    stat.shift_end = (idx_plus >= {1'b0, cnt});
    stat.in_range  = (CMP_W'(pos_q) < CMP_W'(cnt));
    stat.out_free  = !out_valid || !out_stall;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= stat_q;
      read_member  <= read_val;
      member_count <= COUNT_W'(cnt);
    end
  end

  // count stays within capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_MEMBERS))
    else $error("member count above capacity");

  // tail write only when there is room
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (cnt < CNT_W'(MAX_MEMBERS)))
    else $error("append into a full list");

  // remove only from a non-empty list
  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (cnt != '0))
    else $error("count decrement on empty list");

  // shift writes stay inside the held entries
  a_shift_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> (idx_plus < {1'b0, cnt}))
    else $error("shift outside held entries");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(status) && $stable(member_count)))
    else $error("stalled result changed");

endmodule

@@ rtl/bounded_ordered_member_set.sv @@
// bounded ordered member set: top level
// Keeps an ordered, packed list of up to MAX_MEMBERS distinct 8-bit member
// numbers. Input channel (in_valid / in_stall) carries kind, member_number and
// slot_position; a request is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall) carries status, read_member and
// member_count, one result per request, taken when out_valid is high and
// out_stall low.
// One request is in work at a time; the block steps a member memory with
// one write port and a registered read port, one entry at a time (a fetch,
// then a check while scanning or a shift write while moving). Per request:
//   clear, add to a full list or out-of-range read: straight to done; read:
//   one memory read; add: a scan to a match or to the tail, where it appends;
//   remove: a scan up to the match, then one move down per later entry.
// The next request is taken the cycle after a result is loaded into the
// output register, while that result may still wait there.
// Reset empties the list and drops any pending result; no clearing pass.
// When the receiver stalls, the result holds steady and a finished request
// waits in its last state until the output register frees up.
`timescale 1ns / 1ps

module bounded_ordered_member_set
  import bomset_pkg::*;
#(
  parameter int MAX_MEMBERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [MEMBER_W-1:0] member_number,
  input  logic [POS_W-1:0]    slot_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [MEMBER_W-1:0] read_member,
  output logic [COUNT_W-1:0]  member_count
);

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencing
  bomset_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result
  bomset_dp #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .member_number (member_number),
    .slot_position (slot_position),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .read_member   (read_member),
    .member_count  (member_count)
  );

endmodule

@@ dv/tb_bounded_ordered_member_set.sv @@
// self-checking testbench for the bounded ordered member set
`timescale 1ns / 1ps

module tb_bounded_ordered_member_set
  import bomset_pkg::*;
();

  localparam int SET_DEPTH = 16;
  localparam int DRAIN_CYCLES = 2 * SET_DEPTH + 16;

  // one expected result of a request
  typedef struct packed {
    status_t            stat;
    logic [MEMBER_W-1:0] member;
    logic [COUNT_W-1:0]  count;
  } set_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = '0;
  logic [MEMBER_W-1:0] member_number = '0;
  logic [POS_W-1:0]    slot_position = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [MEMBER_W-1:0] read_member;
  logic [COUNT_W-1:0]  member_count;

  // predicted contents of the set
  logic [MEMBER_W-1:0] roster_slots [SET_DEPTH];
  int                  roster_count = 0;

  set_result_t pending_results[$];
  int          error_count = 0;
  bit          gaps_on = 1'b0;
  int          stall_left = 0;

  bounded_ordered_member_set #(
    .MAX_MEMBERS(SET_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .member_number(member_number),
    .slot_position(slot_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .read_member(read_member),
    .member_count(member_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one request to the predicted set and return its result
  function automatic set_result_t apply_request(kind_t op, logic [MEMBER_W-1:0] num,
                                                logic [POS_W-1:0] pos);
    set_result_t r;
    int hit;
    r.stat = STAT_OK;
    r.member = '0;
    hit = -1;
    if (op == KIND_ADD || op == KIND_REMOVE) begin
      for (int i = roster_count - 1; i >= 0; i--) begin
        if (roster_slots[i] == num) hit = i;
      end
    end
    case (op)
      KIND_ADD: begin
        // fullness wins over a duplicate
        if (roster_count >= SET_DEPTH) begin
          r.stat = STAT_FULL;
        end else if (hit >= 0) begin
          r.stat = STAT_PRESENT;
        end else begin
          roster_slots[roster_count] = num;
          roster_count++;
        end
      end
      KIND_REMOVE: begin
        if (hit < 0) begin
          r.stat = STAT_NOT_FOUND;
        end else begin
          for (int j = hit; j < roster_count - 1; j++) roster_slots[j] = roster_slots[j + 1];
          roster_count--;
        end
      end
      KIND_CLEAR: begin
        roster_count = 0;
      end
      default: begin
        if (pos < roster_count) r.member = roster_slots[pos];
        else r.stat = STAT_RANGE;
      end
    endcase
    r.count = roster_count[COUNT_W-1:0];
    return r;
  endfunction

  // send one request, with an optional idle burst before it
  task automatic send_request(kind_t op, logic [MEMBER_W-1:0] num, logic [POS_W-1:0] pos);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= op;
    member_number <= num;
    slot_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(op, num, pos));
  endtask

  // hold the sender until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // empty list: out of range read, remove of an absent number
  task automatic test_empty_list();
    send_request(KIND_READ, 8'hFF, 6'd0);
    send_request(KIND_READ, 8'h00, 6'd63);
    send_request(KIND_REMOVE, 8'd5, 6'd63);
    wait_drained();
  endtask

  // fill to the limit, then adds when full (new and held numbers)
  task automatic test_fill_to_full();
    send_request(KIND_ADD, 8'd0, 6'd63);
    send_request(KIND_ADD, 8'd255, 6'd0);
    for (int i = 1; i <= SET_DEPTH - 2; i++) send_request(KIND_ADD, 8'(i * 17), 6'($urandom));
    send_request(KIND_ADD, 8'd17, 6'd0);
    send_request(KIND_ADD, 8'd100, 6'd0);
    send_request(KIND_READ, 8'd0, 6'(SET_DEPTH - 1));
    wait_drained();
  endtask

  // remove from the middle, duplicate add, clear, read after clear
  task automatic test_remove_and_clear();
    send_request(KIND_REMOVE, 8'd17, 6'd63);
    send_request(KIND_READ, 8'd255, 6'd2);
    send_request(KIND_ADD, 8'd255, 6'd0);
    send_request(KIND_CLEAR, 8'hA5, 6'd42);
    send_request(KIND_READ, 8'd0, 6'd0);
    wait_drained();
  endtask

  // random mix biased toward held numbers and in-range positions
  task automatic test_random_mix(int n_requests);
    int                  roll;
    kind_t               op;
    logic [MEMBER_W-1:0] num;
    logic [POS_W-1:0]    pos;
    for (int i = 0; i < n_requests; i++) begin
      roll = $urandom_range(0, 99);
      num = 8'($urandom_range(0, 255));
      pos = 6'($urandom_range(0, 63));
      if (roll < 40) begin
        op = KIND_ADD;
        // a small pool makes duplicates and later removes likely
        if ($urandom_range(0, 1) == 0)
          num = 8'($urandom_range(0, 19) + ($urandom_range(0, 1) ? 236 : 0));
      end else if (roll < 65) begin
        op = KIND_REMOVE;
        if (roster_count > 0 && $urandom_range(0, 9) < 7)
          num = roster_slots[$urandom_range(0, roster_count - 1)];
      end else if (roll < 97) begin
        op = KIND_READ;
        if ($urandom_range(0, 4) != 0) pos = 6'($urandom_range(0, roster_count));
      end else begin
        op = KIND_CLEAR;
      end
      send_request(op, num, pos);
    end
    wait_drained();
  endtask

  // sender pauses for a full drain every few requests
  task automatic test_drain_pressure();
    for (int k = 0; k < 8; k++) begin
      test_random_mix($urandom_range(3, 10));
    end
  endtask

  // receiver stalls in random bursts while gaps_on is set
  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0d read %0d count %0d",
               status, read_member, member_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, status);
          error_count++;
        end
        if (read_member !== want.member) begin
          $error("read_member: expected %0d, actual %0d", want.member, read_member);
          error_count++;
        end
        if (member_count !== want.count) begin
          $error("member_count: expected %0d, actual %0d", want.count, member_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_fill_to_full();
    test_remove_and_clear();
    gaps_on = 1'b1;
    test_random_mix(450);
    test_drain_pressure();
    gaps_on = 1'b0;
    test_random_mix(150);
    gaps_on = 1'b1;
    test_random_mix(300);
    // last stretch runs with no idling on either side
    gaps_on = 1'b0;
    test_random_mix(150);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
